// File: hw/rtl/wgd_pkg.sv
// ----------------------------------------------------------------------------
// wgd_pkg
// shared constants, codes and types of the windowed genotype distance block
// ----------------------------------------------------------------------------
package wgd_pkg;

	localparam int WINDOW       = 8;
	localparam int SLOTS        = WINDOW + 1;
	localparam int MAX_SUBJECTS = 4096;

	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int SUBJ_W  = $clog2(MAX_SUBJECTS);
	localparam int CNT_W   = $clog2(MAX_SUBJECTS + 1);
	localparam int HELD_W  = $clog2(WINDOW + 1);
	localparam int LANE_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int DIST_W  = CNT_W + 1;
	localparam int FRAC_W  = 16;
	localparam int NUM_W   = DIST_W + FRAC_W;
	localparam int STEP_W  = $clog2(NUM_W + 1);
	localparam int POS_W   = 32;
	localparam int GT_W    = 2;
	localparam int Q_W     = 18;
	localparam int OFF_W   = 6;

	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_ADDR_W-1:0] REG_ALLOW_SWAP    = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_SUBJECT_COUNT = 1'b1;

	localparam logic [GT_W-1:0] GT_HET     = 2'd1;
	localparam logic [GT_W-1:0] GT_MISSING = 2'd3;

	// one finished variant: anchor position plus per-lane totals
	typedef struct packed {
		logic [POS_W-1:0]               pos;
		logic [WINDOW-1:0][DIST_W-1:0]  mis;
		logic [WINDOW-1:0][CNT_W-1:0]   used;
	} wgd_rec_t;

endpackage

// File: hw/rtl/wgd_front.sv
// ----------------------------------------------------------------------------
// wgd_front
// accepts genotype words, keeps the window banks and per-lane mismatch counters
// ----------------------------------------------------------------------------
module wgd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [wgd_pkg::POS_W-1:0]     variant_position,
	input  logic [wgd_pkg::GT_W-1:0]      genotype,
	input  logic                          allow_swap,
	input  logic [wgd_pkg::CNT_W-1:0]     subject_count,
	input  logic                          q_full,
	output logic                          q_push,
	output wgd_pkg::wgd_rec_t             q_rec
);
	import wgd_pkg::*;

	logic                  acc;
	logic [SUBJ_W-1:0]     subj_q;
	logic [SLOT_W-1:0]     newest_q;
	logic [HELD_W-1:0]     held_q;
	logic [CNT_W-1:0]      n_eff;
	logic                  last_now;
	logic [SLOT_W-1:0]     anchor_now;

	logic                  v_s1;
	logic [GT_W-1:0]       g_s1;
	logic                  first_s1;
	logic                  last_s1;
	logic                  cmp_s1;
	logic [SLOT_W-1:0]     anchor_s1;
	logic [GT_W-1:0]       rd_s1 [SLOTS];

	logic [POS_W-1:0]      pos_q [SLOTS];
	logic [CNT_W-1:0]      used_q [WINDOW];
	logic [CNT_W-1:0]      het_q  [WINDOW];
	logic [CNT_W-1:0]      same_q [WINDOW];
	logic [CNT_W-1:0]      swap_q [WINDOW];
	logic [CNT_W-1:0]      used_nx [WINDOW];
	logic [CNT_W-1:0]      het_nx  [WINDOW];
	logic [CNT_W-1:0]      same_nx [WINDOW];
	logic [CNT_W-1:0]      swap_nx [WINDOW];

	assign full = v_s1 | q_full;
	assign acc  = push & ~full;

	always_comb begin
		if (subject_count == '0)
			n_eff = CNT_W'(1);
		else if (subject_count > CNT_W'(MAX_SUBJECTS))
			n_eff = CNT_W'(MAX_SUBJECTS);
		else
			n_eff = subject_count;
	end

	assign last_now   = ({1'b0, subj_q} + CNT_W'(1)) >= n_eff;
	assign anchor_now = (newest_q == SLOT_W'(SLOTS - 1)) ? '0 : newest_q + SLOT_W'(1);

	// one bank per slot, written only for the newest slot
	for (genvar b = 0; b < SLOTS; b++) begin : g_bank
		logic [GT_W-1:0] bank [MAX_SUBJECTS];
		logic [GT_W-1:0] bank_rd;
		always_ff @(posedge clk) begin
			if (acc && newest_q == SLOT_W'(b))
				bank[subj_q] <= genotype;
			if (acc)
				bank_rd <= bank[subj_q];
		end
		assign rd_s1[b] = bank_rd;
	end

	always_ff @(posedge clk) begin
		if (acc && subj_q == '0)
			pos_q[newest_q] <= variant_position;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subj_q   <= '0;
			newest_q <= '0;
			held_q   <= '0;
			v_s1     <= 1'b0;
		end else begin
			v_s1 <= acc;
			if (acc) begin
				if (last_now) begin
					subj_q   <= '0;
					newest_q <= anchor_now;
					if (held_q < HELD_W'(WINDOW))
						held_q <= held_q + HELD_W'(1);
				end else begin
					subj_q <= subj_q + SUBJ_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			g_s1      <= genotype;
			first_s1  <= (subj_q == '0);
			last_s1   <= last_now;
			cmp_s1    <= (held_q >= HELD_W'(WINDOW));
			anchor_s1 <= anchor_now;
		end
	end

	// compare anchor with each newer slot, one lane per offset
	always_comb begin
		logic [GT_W-1:0]   a;
		logic [GT_W-1:0]   bg;
		logic [SLOT_W:0]   sum;
		logic [SLOT_W-1:0] slot;
		logic              has_het;
		a = rd_s1[anchor_s1];
		for (int v = 0; v < WINDOW; v++) begin
			sum = {1'b0, anchor_s1} + (SLOT_W + 1)'(v + 1);
			if (sum >= (SLOT_W + 1)'(SLOTS))
				sum = sum - (SLOT_W + 1)'(SLOTS);
			slot = sum[SLOT_W-1:0];
			bg = (v == WINDOW - 1) ? g_s1 : rd_s1[slot];
			used_nx[v] = first_s1 ? '0 : used_q[v];
			het_nx[v]  = first_s1 ? '0 : het_q[v];
			same_nx[v] = first_s1 ? '0 : same_q[v];
			swap_nx[v] = first_s1 ? '0 : swap_q[v];
			has_het = (a == GT_HET) || (bg == GT_HET);
			if (cmp_s1 && a != GT_MISSING && bg != GT_MISSING) begin
				used_nx[v] = used_nx[v] + CNT_W'(1);
				if (has_het) begin
					if (a != bg)
						het_nx[v] = het_nx[v] + CNT_W'(1);
				end else if (a == bg) begin
					swap_nx[v] = swap_nx[v] + CNT_W'(1);
				end else begin
					same_nx[v] = same_nx[v] + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < WINDOW; v++) begin
				used_q[v] <= '0;
				het_q[v]  <= '0;
				same_q[v] <= '0;
				swap_q[v] <= '0;
			end
		end else if (v_s1) begin
			for (int v = 0; v < WINDOW; v++) begin
				used_q[v] <= used_nx[v];
				het_q[v]  <= het_nx[v];
				same_q[v] <= same_nx[v];
				swap_q[v] <= swap_nx[v];
			end
		end
	end

	// variant done: hand totals to the back end
	always_comb begin
		logic [CNT_W-1:0] hom;
		q_push    = v_s1 & last_s1 & cmp_s1;
		q_rec.pos = pos_q[anchor_s1];
		for (int v = 0; v < WINDOW; v++) begin
			hom = same_nx[v];
			if (allow_swap && swap_nx[v] < hom)
				hom = swap_nx[v];
			q_rec.mis[v]  = DIST_W'(het_nx[v]) + {hom, 1'b0};
			q_rec.used[v] = used_nx[v];
		end
	end

endmodule

// File: hw/rtl/wgd_queue.sv
// ----------------------------------------------------------------------------
// wgd_queue
// two-entry queue of finished variant records between front and back
// ----------------------------------------------------------------------------
module wgd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  wgd_pkg::wgd_rec_t wr_rec,
	output logic              q_full,
	input  logic              rd,
	output logic              q_empty,
	output wgd_pkg::wgd_rec_t rd_rec
);
	import wgd_pkg::*;

	wgd_rec_t    mem_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rd_rec  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= ~wp_q;
			if (rd)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

// File: hw/rtl/wgd_back.sv
// ----------------------------------------------------------------------------
// wgd_back
// per-lane bit-serial divide and result word register
// ----------------------------------------------------------------------------
module wgd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  wgd_pkg::wgd_rec_t             rec,
	output logic                          q_pop,
	output logic                          empty,
	input  logic                          pop,
	output logic [wgd_pkg::POS_W-1:0]     anchor_position,
	output logic [wgd_pkg::OFF_W-1:0]     offset,
	output logic [wgd_pkg::Q_W-1:0]       distance,
	output logic                          no_valid_pairs,
	output logic                          last_of_run
);
	import wgd_pkg::*;

	typedef enum logic [1:0] {IDLE, DIV, HOLD} state_t;

	state_t             state_q;
	logic [LANE_W-1:0]  lane_q;
	logic [NUM_W-1:0]   num_q;
	logic [CNT_W-1:0]   den_q;
	logic [CNT_W-1:0]   rem_q;
	logic [Q_W-1:0]     quo_q;
	logic [STEP_W-1:0]  step_q;
	logic               out_v_q;
	logic [CNT_W:0]     rem_sh;
	logic               fit;
	logic               out_free;
	logic               lane_last;

	assign rem_sh    = {rem_q, num_q[NUM_W-1]};
	assign fit       = rem_sh >= {1'b0, den_q};
	assign out_free  = ~out_v_q | pop;
	assign lane_last = (lane_q == LANE_W'(WINDOW - 1));
	assign q_pop     = (state_q == HOLD) & out_free & lane_last;
	assign empty     = ~out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			lane_q  <= '0;
			out_v_q <= 1'b0;
			step_q  <= '0;
		end else begin
			// new word loads as the old one leaves
			if (state_q == HOLD && out_free)
				out_v_q <= 1'b1;
			else if (pop && out_v_q)
				out_v_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (!q_empty) begin
						num_q   <= {rec.mis[lane_q], FRAC_W'(0)};
						den_q   <= rec.used[lane_q];
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= DIV;
					end
				end
				DIV: begin
					num_q  <= num_q << 1;
					rem_q  <= fit ? CNT_W'(rem_sh - {1'b0, den_q}) : rem_sh[CNT_W-1:0];
					quo_q  <= {quo_q[Q_W-2:0], fit};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(NUM_W - 1))
						state_q <= HOLD;
				end
				HOLD: begin
					if (out_free) begin
						anchor_position <= rec.pos;
						offset          <= OFF_W'(lane_q) + OFF_W'(1);
						no_valid_pairs  <= (den_q == '0);
						distance        <= (den_q == '0) ? '0 : quo_q;
						last_of_run     <= lane_last;
						lane_q          <= lane_last ? '0 : lane_q + LANE_W'(1);
						state_q         <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/windowed_genotype_distance_top.sv
// ----------------------------------------------------------------------------
// windowed_genotype_distance_top
// sliding-window genotype mismatch rates between an anchor variant and its
// WINDOW successors
// ----------------------------------------------------------------------------
// intake: each accepted genotype word has its bank read, then its lane update; full stays high
//   meanwhile, so the next word is not taken until the last one has updated the lanes
// results: WINDOW words per finished variant, divided lane by lane by the shared bit-serial
//   divider in the back end
// reset: arst_n clears control, counters and config; genotype banks and
//   positions stay undefined until written, no clearing pass
// ----------------------------------------------------------------------------
module windowed_genotype_distance_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [wgd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [wgd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              push,
	output logic                              full,
	input  logic [wgd_pkg::POS_W-1:0]         variant_position,
	input  logic [wgd_pkg::GT_W-1:0]          genotype,
	output logic                              empty,
	input  logic                              pop,
	output logic [wgd_pkg::POS_W-1:0]         anchor_position,
	output logic [wgd_pkg::OFF_W-1:0]         offset,
	output logic [wgd_pkg::Q_W-1:0]           distance,
	output logic                              no_valid_pairs,
	output logic                              last_of_run
);
	import wgd_pkg::*;

	// configuration registers
	logic              allow_swap_q;
	logic [CNT_W-1:0]  subject_count_q;

	// front to queue
	logic              q_push;
	wgd_rec_t          q_wr_rec;
	logic              q_full;

	// queue to back
	logic              q_pop;
	logic              q_empty;
	wgd_rec_t          q_rd_rec;

	// config writes land directly, no handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_swap_q    <= 1'b0;
			subject_count_q <= CNT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ALLOW_SWAP:    allow_swap_q    <= cfg_wdata[0];
				REG_SUBJECT_COUNT: subject_count_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// front: take words, store in banks, update per-offset counters
	wgd_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.variant_position (variant_position),
		.genotype         (genotype),
		.allow_swap       (allow_swap_q),
		.subject_count    (subject_count_q),
		.q_full           (q_full),
		.q_push           (q_push),
		.q_rec            (q_wr_rec)
	);

	// short queue so a slow divide does not stall word intake at once
	wgd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_rec  (q_wr_rec),
		.q_full  (q_full),
		.rd      (q_pop),
		.q_empty (q_empty),
		.rd_rec  (q_rd_rec)
	);

	// back: divide each lane and present result words
	wgd_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.rec             (q_rd_rec),
		.q_pop           (q_pop),
		.empty           (empty),
		.pop             (pop),
		.anchor_position (anchor_position),
		.offset          (offset),
		.distance        (distance),
		.no_valid_pairs  (no_valid_pairs),
		.last_of_run     (last_of_run)
	);

endmodule

// File: hw/rtl/wgd_checker.sv
// ----------------------------------------------------------------------------
// wgd_checker
// port-level checks on result words
// ----------------------------------------------------------------------------
module wgd_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              empty,
	input  logic                              pop,
	input  logic [wgd_pkg::OFF_W-1:0]         offset,
	input  logic [wgd_pkg::Q_W-1:0]           distance,
	input  logic                              no_valid_pairs,
	input  logic                              last_of_run
);
	import wgd_pkg::*;

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (offset >= OFF_W'(1) && offset <= OFF_W'(WINDOW)))
		else $error("offset out of range");

	a_last_match: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (last_of_run == (offset == OFF_W'(WINDOW))))
		else $error("last_of_run does not match offset");

	a_no_pairs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && no_valid_pairs) |-> (distance == '0))
		else $error("distance nonzero without valid pairs");

	a_dist_max: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (distance <= Q_W'(2 << FRAC_W)))
		else $error("distance above two");

endmodule

bind windowed_genotype_distance_top wgd_checker u_wgd_checker (.*);

// File: dv/windowed_genotype_distance_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_genotype_distance_top_tb
// streams genotype words through the windowed distance block under bursty
// input and a stalling reader, predicts every result word in the bench and
// checks each one field by field in arrival order
// ----------------------------------------------------------------------------
module windowed_genotype_distance_top_tb;
	import wgd_pkg::*;

	localparam int LIMIT_CYCLES = 1500000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES  = 3000;

	// homozygote dosage codes, the other two come from the package
	localparam logic [GT_W-1:0] GT_HOM_REF = 2'd0;
	localparam logic [GT_W-1:0] GT_HOM_ALT = 2'd2;

	typedef struct {
		logic [POS_W-1:0] pos;
		logic [GT_W-1:0]  gt;
	} gt_word_t;

	typedef struct {
		logic [POS_W-1:0] anchor;
		logic [OFF_W-1:0] off;
		logic [Q_W-1:0]   rate;
		logic             nvp;
		logic             last;
	} rate_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  push;
	logic                  full;
	logic [POS_W-1:0]      variant_position;
	logic [GT_W-1:0]       genotype;
	logic                  empty;
	logic                  pop;
	logic [POS_W-1:0]      anchor_position;
	logic [OFF_W-1:0]      offset;
	logic [Q_W-1:0]        distance;
	logic                  no_valid_pairs;
	logic                  last_of_run;

	windowed_genotype_distance_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.variant_position(variant_position),
		.genotype(genotype),
		.empty(empty),
		.pop(pop),
		.anchor_position(anchor_position),
		.offset(offset),
		.distance(distance),
		.no_valid_pairs(no_valid_pairs),
		.last_of_run(last_of_run)
	);

	// words waiting to be sent, rate words waiting to arrive
	gt_word_t   send_q[$];
	rate_word_t rate_q[$];
	int         errors = 0;
	int         hold_left = 0;

	// bench copy of the block state
	logic [GT_W-1:0]  gt_bank [SLOTS][MAX_SUBJECTS];
	logic [POS_W-1:0] pos_bank [SLOTS];
	int               newest = 0;
	int               held = 0;
	int               subj = 0;
	int               used_n [WINDOW];
	int               het_n [WINDOW];
	int               same_n [WINDOW];
	int               swap_n [WINDOW];
	logic             swap_en = 1'b0;
	logic [12:0]      subj_cfg = 13'd1;

	// prototype genotypes so that windows share structure
	logic [GT_W-1:0]  proto [8];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// prediction: one accepted genotype word, pushes WINDOW rate words when a
	// variant closes with a full window
	// ------------------------------------------------------------------------
	function automatic void predict_rates(input gt_word_t w);
		int n, s, anc, sl;
		logic [GT_W-1:0] a, b;
		longint unsigned hom, wsum, q;
		rate_word_t r;
		n = (subj_cfg == 0) ? 1 : ((subj_cfg > MAX_SUBJECTS) ? MAX_SUBJECTS : subj_cfg);
		s = (subj >= MAX_SUBJECTS) ? MAX_SUBJECTS - 1 : subj;
		if (s == 0) begin
			// position latches on subject 0 only
			pos_bank[newest] = w.pos;
			for (int v = 0; v < WINDOW; v++) begin
				used_n[v] = 0; het_n[v] = 0; same_n[v] = 0; swap_n[v] = 0;
			end
		end
		gt_bank[newest][s] = w.gt;
		anc = (newest + 1) % SLOTS;
		if (held >= WINDOW) begin
			a = gt_bank[anc][s];
			for (int v = 0; v < WINDOW; v++) begin
				sl = (anc + v + 1) % SLOTS;
				b = gt_bank[sl][s];
				// missing on either side drops the pair
				if (a != GT_MISSING && b != GT_MISSING) begin
					used_n[v]++;
					if (a == GT_HET || b == GT_HET) begin
						if (a != b) het_n[v]++;
					end else if (a == b) begin
						swap_n[v]++;
					end else begin
						same_n[v]++;
					end
				end
			end
		end
		if (s + 1 >= n) begin
			if (held >= WINDOW) begin
				for (int v = 0; v < WINDOW; v++) begin
					hom = same_n[v];
					if (swap_en && swap_n[v] < hom) hom = swap_n[v];
					wsum = het_n[v] + 2 * hom;
					q = (used_n[v] != 0) ? (wsum << 16) / used_n[v] : 0;
					r.anchor = pos_bank[anc];
					r.off    = OFF_W'(v + 1);
					r.rate   = q[Q_W-1:0];
					r.nvp    = (used_n[v] == 0);
					r.last   = (v + 1 == WINDOW);
					rate_q.push_back(r);
				end
			end
			newest = (newest + 1) % SLOTS;
			if (held < WINDOW) held++;
			subj = 0;
		end else begin
			subj = s + 1;
		end
	endfunction

	// ------------------------------------------------------------------------
	// driver: bursts of random length with random gaps
	// ------------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (push && !full) begin
			predict_rates(send_q[0]);
			void'(send_q.pop_front());
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			push <= 1'b0;
		end else if (send_q.size() > 0) begin
			push <= 1'b1;
			variant_position <= send_q[0].pos;
			genotype <= send_q[0].gt;
			if (burst_left <= 1) begin
				// long bursts now and then give stretches with no gaps
				burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
				                                          : $urandom_range(1, 12);
				gap_left <= $urandom_range(0, 4);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			push <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// receiver: rotating stall pattern, plus a long hold-off on request
	// ------------------------------------------------------------------------
	logic [15:0] pop_pat = 16'hffff;
	int          pat_left = 0;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= pop_pat[0];
			if (pat_left == 0) begin
				case ($urandom_range(0, 2))
					0: pop_pat <= 16'hffff;
					1: pop_pat <= 16'($urandom);
					default: pop_pat <= 16'($urandom) | 16'($urandom);
				endcase
				pat_left <= $urandom_range(16, 128);
			end else begin
				pop_pat <= {pop_pat[0], pop_pat[15:1]};
				pat_left <= pat_left - 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: compare each accepted rate word with the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rate_word_t e;
		if (pop && !empty) begin
			if (rate_q.size() == 0) begin
				$error("rate word with none predicted: anchor %0h offset %0d",
				       anchor_position, offset);
				errors++;
			end else begin
				e = rate_q.pop_front();
				if (anchor_position !== e.anchor) begin
					$error("anchor_position exp %0h got %0h", e.anchor, anchor_position);
					errors++;
				end
				if (offset !== e.off) begin
					$error("offset exp %0d got %0d", e.off, offset);
					errors++;
				end
				if (distance !== e.rate) begin
					$error("distance exp %0h got %0h", e.rate, distance);
					errors++;
				end
				if (no_valid_pairs !== e.nvp) begin
					$error("no_valid_pairs exp %0b got %0b", e.nvp, no_valid_pairs);
					errors++;
				end
				if (last_of_run !== e.last) begin
					$error("last_of_run exp %0b got %0b", e.last, last_of_run);
					errors++;
				end
			end
		end
	end

	// run limit
	int cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [GT_W-1:0] rand_gt();
		case ($urandom_range(0, 9))
			0, 1, 2: return GT_HOM_REF;
			3, 4, 5: return GT_HOM_ALT;
			6, 7:    return GT_HET;
			default: return GT_MISSING;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] rand_pos();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// one variant of n words; later subjects carry junk positions
	task automatic queue_variant(input int n, input logic [POS_W-1:0] p,
	                             input logic [GT_W-1:0] g []);
		gt_word_t w;
		for (int i = 0; i < n; i++) begin
			w.pos = (i == 0) ? p : rand_pos();
			w.gt  = g[i];
			send_q.push_back(w);
		end
	endtask

	// random variant: fresh, copy of prototype, allele flip of it, or noisy copy
	task automatic queue_rand_variant(input int n);
		logic [GT_W-1:0] g [];
		int mode;
		g = new[n];
		mode = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: g[i] = rand_gt();
				1: g[i] = proto[i % 8];
				2: g[i] = (proto[i % 8] == GT_HOM_REF) ? GT_HOM_ALT :
				          (proto[i % 8] == GT_HOM_ALT) ? GT_HOM_REF : proto[i % 8];
				default: g[i] = ($urandom_range(0, 3) == 0) ? rand_gt() : proto[i % 8];
			endcase
		end
		if ($urandom_range(0, 5) == 0)
			for (int i = 0; i < 8; i++) proto[i] = rand_gt();
		queue_variant(n, rand_pos(), g);
	endtask

	task automatic queue_flat(input int n, input logic [GT_W-1:0] gv,
	                          input logic [POS_W-1:0] p);
		logic [GT_W-1:0] g [];
		g = new[n];
		foreach (g[i]) g[i] = gv;
		queue_variant(n, p, g);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [12:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= a;
		cfg_wdata <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (a == REG_ALLOW_SWAP) swap_en = d[0];
		else subj_cfg = d;
	endtask

	// everything sent and every rate word back, then the divider tail
	task automatic settle();
		wait (send_q.size() == 0 && !push && rate_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// test sequence; subject count only goes down once variants are held so
	// no never-written genotype is ever compared
	// ------------------------------------------------------------------------
	initial begin
		logic [GT_W-1:0] mix [];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		push = 1'b0;
		pop = 1'b0;
		variant_position = '0;
		genotype = '0;
		for (int i = 0; i < 8; i++) proto[i] = rand_gt();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// count beyond the maximum saturates; drop it to three mid-variant so
		// the third word closes the first variant
		write_reg(REG_ALLOW_SWAP, 13'd0);
		write_reg(REG_SUBJECT_COUNT, 13'h1fff);
		mix = new[3];
		foreach (mix[i]) mix[i] = rand_gt();
		queue_variant(2, rand_pos(), mix);
		settle();
		write_reg(REG_SUBJECT_COUNT, 13'd3);
		queue_variant(1, rand_pos(), mix);
		settle();

		// directed, three subjects: flat homs, hets, all missing, mixed
		write_reg(REG_ALLOW_SWAP, 13'd1);
		mix[0] = GT_HET; mix[1] = GT_MISSING; mix[2] = GT_HOM_ALT;
		queue_flat(3, GT_HOM_REF, '0);
		queue_flat(3, GT_HOM_ALT, '1);
		queue_flat(3, GT_HET, 32'h1234_5678);
		queue_flat(3, GT_MISSING, 32'h8000_0000);
		queue_variant(3, 32'h0000_0001, mix);
		queue_flat(3, GT_HOM_REF, 32'hffff_fffe);
		queue_flat(3, GT_HOM_ALT, 32'h7fff_ffff);
		queue_flat(3, GT_HET, 32'h5555_aaaa);
		settle();

		// random, both orientations
		write_reg(REG_ALLOW_SWAP, 13'd0);
		repeat (30) queue_rand_variant(3);
		settle();
		write_reg(REG_ALLOW_SWAP, 13'd1);
		repeat (30) queue_rand_variant(3);
		settle();

		// lower the count mid-variant; zero acts as one, so the next word closes it
		mix[0] = rand_gt(); mix[1] = rand_gt();
		queue_variant(2, rand_pos(), mix);
		settle();
		write_reg(REG_SUBJECT_COUNT, 13'd0);

		// one subject per variant: eight rate words per word, long reader hold
		hold_left = HOLD_CYCLES;
		repeat (110) queue_rand_variant(1);
		settle();
		write_reg(REG_ALLOW_SWAP, 13'd0);
		repeat (110) queue_rand_variant(1);
		settle();

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
